### sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Sizes, field widths, request and status codes, per-cell control.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int MODE_W     = 2;
  localparam int POS_W      = 7;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int FIDX_W     = 6;
  localparam int COUNT_W    = 7;

  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_FIND   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_POS = 2'd2,
    STATUS_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [POS_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] word;
  } cell_ctl_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

### sv/ple_if.sv
// ----------------------------------------------------------------------------
// ple_if: request and result channels of the positional list engine
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ple_in_if;
  import ple_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source(output valid, output mode, output position, output value, input ready);
  modport sink(input valid, input mode, input position, input value, output ready);
endinterface

interface ple_out_if;
  import ple_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [FIDX_W-1:0]   found_index;
  logic [COUNT_W-1:0]  count;

  modport source(output valid, output status, output found, output found_index,
                 output count, input ready);
  modport sink(input valid, input status, input found, input found_index,
               input count, output ready);
endinterface

### sv/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one list slot
// Holds one entry, takes a neighbor's word on insert or erase shifts and
// compares its entry with the search key.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                           clk,
  input  logic [ple_pkg::IDX_W-1:0]      cell_idx,
  input  ple_pkg::cell_ctl_t             ctl,
  input  logic [ple_pkg::DATA_WIDTH-1:0] left_data,
  input  logic [ple_pkg::DATA_WIDTH-1:0] right_data,
  input  logic [ple_pkg::DATA_WIDTH-1:0] key,
  output logic [ple_pkg::DATA_WIDTH-1:0] data,
  output logic                           match
);
  import ple_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic [CMP_W-1:0]      idx_x;
  logic [CMP_W-1:0]      pos_x;

  assign idx_x = CMP_W'(cell_idx);
  assign pos_x = CMP_W'(ctl.pos);

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INSERT: begin
        // slots above the target move up, the target takes the new word
        if (idx_x > pos_x) begin
          data_nxt = left_data;
        end else if (idx_x == pos_x) begin
          data_nxt = ctl.word;
        end
      end
      CELL_ERASE: begin
        if (idx_x >= pos_x) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

### sv/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl: request sequencer of the positional list engine
// Checks requests, drives the cell row, scans match flags for a find and
// holds the result register.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  ple_in_if.sink                         in_ch,
  ple_out_if.source                      out_ch,
  input  logic [ple_pkg::CAPACITY-1:0]   match,
  output ple_pkg::cell_ctl_t             cell_ctl,
  output logic [ple_pkg::DATA_WIDTH-1:0] key
);
  import ple_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      length_r, length_nxt;
  logic [IDX_W-1:0]      scan_r, scan_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic                  found_r, found_nxt;
  logic [FIDX_W-1:0]     fidx_r, fidx_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;

  logic                  in_fire;
  logic                  find_start;
  logic                  scan_hit;
  logic                  scan_end;
  mode_t                 req_mode;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      len_x;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign req_mode    = mode_t'(in_ch.mode);
  assign pos_x       = CMP_W'(in_ch.position);
  assign len_x       = CMP_W'(length_r);
  assign find_start  = in_fire && (req_mode == MODE_FIND) && (length_r != '0);
  assign scan_hit    = match[scan_r];
  assign scan_end    = (CNT_W'(CNT_W'(scan_r) + CNT_W'(1)) == length_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (find_start) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_hit || scan_end) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    length_nxt    = length_r;
    scan_nxt      = scan_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    count_nxt     = count_r;
    cell_ctl.op   = CELL_HOLD;
    cell_ctl.pos  = in_ch.position;
    cell_ctl.word = DATA_WIDTH'(in_ch.value);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_OK;
          found_nxt     = 1'b0;
          fidx_nxt      = '0;
          case (req_mode)
            MODE_INSERT: begin
              if (length_r >= CNT_W'(CAPACITY)) begin
                status_nxt = STATUS_FULL;
              end else if (pos_x > len_x) begin
                status_nxt = STATUS_BAD_POS;
              end else begin
                cell_ctl.op = CELL_INSERT;
                length_nxt  = CNT_W'(length_r + CNT_W'(1));
              end
            end
            MODE_ERASE: begin
              if (length_r == '0) begin
                status_nxt = STATUS_EMPTY;
              end else if (pos_x >= len_x) begin
                status_nxt = STATUS_BAD_POS;
              end else begin
                cell_ctl.op = CELL_ERASE;
                length_nxt  = CNT_W'(length_r - CNT_W'(1));
              end
            end
            MODE_FIND: begin
              // empty list answers at once, otherwise start the scan
              if (length_r != '0) begin
                out_valid_nxt = 1'b0;
                key_nxt       = DATA_WIDTH'(in_ch.value);
                scan_nxt      = '0;
              end
            end
            default: status_nxt = STATUS_OK;
          endcase
          count_nxt = COUNT_W'(length_nxt);
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_OK;
          found_nxt     = 1'b1;
          fidx_nxt      = FIDX_W'(scan_r);
          count_nxt     = COUNT_W'(length_r);
        end else if (scan_end) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_OK;
          found_nxt     = 1'b0;
          fidx_nxt      = '0;
          count_nxt     = COUNT_W'(length_r);
        end else begin
          scan_nxt = IDX_W'(scan_r + IDX_W'(1));
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    fidx_r   <= fidx_nxt;
    count_r  <= count_nxt;
  end

  assign key                = key_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.found       = found_r;
  assign out_ch.found_index = fidx_r;
  assign out_ch.count       = count_r;

endmodule

### sv/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of words with positional edits
// Insert at a position, erase at a position, or find the lowest index of a
// value; every request returns one result with status and entry count.
//
// Requests arrive on in_ch (mode, position, value), results leave on out_ch
// (status, found, found_index, count), both valid/ready.
// The list lives in a row of cells, one per slot; an insert or erase moves
// every later slot by one neighbor, all slots shifting together.
// Insert, erase, rejected and unknown requests: result valid in the cycle after
// the request is taken, one request per cycle while results are taken.
// Find: the sequencer checks the cells' match flags one slot per cycle from
// index 0 and answers at the first hit or after the last entry; an empty
// list answers without a scan, like the other requests. No request is
// taken during the scan.
// Reset empties the list at once (count 0) and drops any pending result;
// slot contents are not cleared and are only read below the count.
// A stalled result stays in the output register; a new request is taken
// only in the cycle the waiting result leaves or once it is gone.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);
  import ple_pkg::*;

  cell_ctl_t             cell_ctl;
  logic [DATA_WIDTH-1:0] key;
  logic [CAPACITY-1:0]   match;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .match    (match),
    .cell_ctl (cell_ctl),
    .key      (key)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctl        (cell_ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .key        (key),
      .data       (cell_data[i]),
      .match      (match[i])
    );
  end

endmodule

### sv/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port-level checks of the positional list engine
// Watches the result channel for held items and consistent result fields.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ple_pkg::STATUS_W-1:0]  out_status,
  input logic                          out_found,
  input logic [ple_pkg::FIDX_W-1:0]    out_found_index,
  input logic [ple_pkg::COUNT_W-1:0]   out_count
);
  import ple_pkg::*;

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= 32'(CAPACITY)))
    else $error("count above capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_status == STATUS_OK) && (out_count != '0))
    else $error("hit reported with bad status or empty list");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_found_index == '0))
    else $error("nonzero index without a hit");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found       (out_ch.found),
  .out_found_index (out_ch.found_index),
  .out_count       (out_ch.count)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for positional_list_engine_unit
// Drives insert, erase, find and unused requests through the request channel,
// keeps a shadow list to predict every result, and compares each result that
// leaves the block with the oldest prediction. A directed table covers empty,
// full and bad-position cases. Random traffic then swings the list between
// empty and full under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  import ple_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = CAPACITY + 16;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [FIDX_W-1:0]   found_index;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    int                 reps;
    bit                 typed;
    list_result_t       result;
  } plan_row_t;

  localparam int PLAN_ROWS = 27;

  // Rows marked typed carry their result; the others are checked by the shadow list.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{MODE_ERASE,  7'd0,   32'h0000_0000, 1,  1'b1, '{STATUS_EMPTY,   1'b0, 6'd0, 7'd0}},
    '{MODE_FIND,   7'd0,   32'h0000_0000, 1,  1'b1, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_UNUSED, 7'd127, 32'hFFFF_FFFF, 1,  1'b1, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_INSERT, 7'd1,   32'hAAAA_5555, 1,  1'b1, '{STATUS_BAD_POS, 1'b0, 6'd0, 7'd0}},
    '{MODE_INSERT, 7'd127, 32'h0000_0000, 1,  1'b1, '{STATUS_BAD_POS, 1'b0, 6'd0, 7'd0}},
    '{MODE_INSERT, 7'd0,   32'hFFFF_FFFF, 1,  1'b1, '{STATUS_OK,      1'b0, 6'd0, 7'd1}},
    '{MODE_INSERT, 7'd1,   32'h0000_0000, 1,  1'b1, '{STATUS_OK,      1'b0, 6'd0, 7'd2}},
    '{MODE_INSERT, 7'd0,   32'h1234_5678, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_FIND,   7'd127, 32'hFFFF_FFFF, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_FIND,   7'd0,   32'h0000_0000, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_FIND,   7'd0,   32'hDEAD_BEEF, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_ERASE,  7'd3,   32'h0000_0000, 1,  1'b1, '{STATUS_BAD_POS, 1'b0, 6'd0, 7'd3}},
    '{MODE_ERASE,  7'd127, 32'hFFFF_FFFF, 1,  1'b1, '{STATUS_BAD_POS, 1'b0, 6'd0, 7'd3}},
    '{MODE_UNUSED, 7'd5,   32'h0000_0000, 1,  1'b1, '{STATUS_OK,      1'b0, 6'd0, 7'd3}},
    '{MODE_ERASE,  7'd1,   32'h0000_0000, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_INSERT, 7'd2,   32'h0000_0000, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_FIND,   7'd0,   32'h0000_0000, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    // fill to capacity from the front, values step up per repetition
    '{MODE_INSERT, 7'd0,   32'h0000_0100, 61, 1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_INSERT, 7'd0,   32'h0000_0000, 1,  1'b1, '{STATUS_FULL,    1'b0, 6'd0, 7'd64}},
    '{MODE_INSERT, 7'd127, 32'h0000_0000, 1,  1'b1, '{STATUS_FULL,    1'b0, 6'd0, 7'd64}},
    '{MODE_FIND,   7'd0,   32'h0000_0000, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_ERASE,  7'd64,  32'h0000_0000, 1,  1'b1, '{STATUS_BAD_POS, 1'b0, 6'd0, 7'd64}},
    '{MODE_ERASE,  7'd63,  32'h0000_0000, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_INSERT, 7'd63,  32'h5555_5555, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_FIND,   7'd0,   32'h5555_5555, 1,  1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_ERASE,  7'd0,   32'h0000_0000, 64, 1'b0, '{STATUS_OK,      1'b0, 6'd0, 7'd0}},
    '{MODE_ERASE,  7'd0,   32'hFFFF_FFFF, 1,  1'b1, '{STATUS_EMPTY,   1'b0, 6'd0, 7'd0}}
  };

  logic clk;
  logic rst_n;

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  positional_list_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow list and results still owed by the block
  logic [DATA_WIDTH-1:0] shadow_words [CAPACITY];
  int                    shadow_len;
  list_result_t          awaited_results [$];

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_list_engine_unit: mismatch");
      $finish;
    end
  end

  // Apply one request to the shadow list and return the result it gives
  function automatic list_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                 input logic [POS_W-1:0] position,
                                                 input logic [VALUE_W-1:0] value);
    list_result_t          res;
    logic [DATA_WIDTH-1:0] word;
    int                    i;
    res = '{STATUS_OK, 1'b0, '0, '0};
    word = value[DATA_WIDTH-1:0];
    case (mode)
      MODE_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else if (int'(position) > shadow_len) begin
          res.status = STATUS_BAD_POS;
        end else begin
          for (i = shadow_len; i > int'(position); i--)
            shadow_words[i] = shadow_words[i-1];
          shadow_words[position] = word;
          shadow_len++;
        end
      end
      MODE_ERASE: begin
        if (shadow_len == 0) begin
          res.status = STATUS_EMPTY;
        end else if (int'(position) >= shadow_len) begin
          res.status = STATUS_BAD_POS;
        end else begin
          for (i = int'(position); i + 1 < shadow_len; i++)
            shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      MODE_FIND: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == word) begin
            res.found = 1'b1;
            res.found_index = i[FIDX_W-1:0];
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = shadow_len[COUNT_W-1:0];
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [POS_W-1:0] position,
                              input logic [VALUE_W-1:0] value,
                              input bit typed,
                              input list_result_t typed_result);
    list_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.position <= position;
    in_ch.value    <= value;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    predicted = apply_request(mode, position, value);
    awaited_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed result has left the block
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    return ($urandom_range(1) == 0) ? $urandom() : VALUE_W'($urandom_range(15));
  endfunction

  // Receiver: stall at random, decided at each falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d found=%0d index=%0d count=%0d",
                 $time, out_ch.status, out_ch.found, out_ch.found_index, out_ch.count);
        error_count++;
      end else begin
        list_result_t want;
        list_result_t got;
        want = awaited_results.pop_front();
        got  = '{status_t'(out_ch.status), out_ch.found, out_ch.found_index, out_ch.count};
        if (got !== want) begin
          $display("%0t: expected status=%0d found=%0d index=%0d count=%0d,",
                   $time, want.status, want.found, want.found_index, want.count,
                   " got status=%0d found=%0d index=%0d count=%0d",
                   got.status, got.found, got.found_index, got.count);
          error_count++;
        end
      end
    end
  end

  initial begin
    int                 row;
    int                 k;
    int                 phase;
    int                 sent;
    int                 r;
    bit                 filling;
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    int                 phase_send [4];
    int                 phase_recv [4];

    phase_send = '{0, 52, 0, 22};
    phase_recv = '{0, 0, 52, 22};
    error_count    = 0;
    cycle_count    = 0;
    shadow_len     = 0;
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.position = '0;
    in_ch.value    = '0;
    rst_n          = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < PLAN_ROWS; row++) begin
      for (k = 0; k < directed_plan[row].reps; k++) begin
        send_request(directed_plan[row].mode, directed_plan[row].position,
                     directed_plan[row].value + VALUE_W'(k),
                     directed_plan[row].typed, directed_plan[row].result);
      end
    end
    drain_results();

    filling = 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = phase_send[phase];
      recv_stall_pct = phase_recv[phase];
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        // swing between empty and full, lingering a little at each end
        if (shadow_len == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
        if (shadow_len == 0 && $urandom_range(3) == 0) filling = 1'b1;
        r = $urandom_range(99);
        position = POS_W'($urandom_range(127));
        value = pick_word();
        if (r < 3) begin
          mode = MODE_UNUSED;
        end else if (r < 28) begin
          mode = MODE_FIND;
          if (shadow_len > 0 && $urandom_range(3) != 0)
            value = shadow_words[$urandom_range(shadow_len - 1)];
        end else begin
          mode = ($urandom_range(99) < (filling ? 75 : 25)) ? MODE_INSERT : MODE_ERASE;
          if ($urandom_range(99) < 85) begin
            if (mode == MODE_INSERT)
              position = POS_W'($urandom_range(shadow_len));
            else
              position = (shadow_len > 0) ? POS_W'($urandom_range(shadow_len - 1)) : '0;
          end
        end
        sent++;
        send_request(mode, position, value, 1'b0, '{STATUS_OK, 1'b0, '0, '0});
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("positional_list_engine_unit: match");
    end else begin
      $display("positional_list_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
